// ----- sv/armdp_pkg.sv -----
`default_nettype none

package armdp_pkg;

  // data-processing opcodes, instruction bits 24..21
  typedef enum logic [3:0] {
    OP_AND = 4'h0,
    OP_EOR = 4'h1,
    OP_SUB = 4'h2,
    OP_RSB = 4'h3,
    OP_ADD = 4'h4,
    OP_ADC = 4'h5,
    OP_SBC = 4'h6,
    OP_RSC = 4'h7,
    OP_TST = 4'h8,
    OP_TEQ = 4'h9,
    OP_CMP = 4'hA,
    OP_CMN = 4'hB,
    OP_ORR = 4'hC,
    OP_MOV = 4'hD,
    OP_BIC = 4'hE,
    OP_MVN = 4'hF
  } op_e;

  // shift type, instruction bits 6..5
  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_e;

  // register index of the program counter
  localparam logic [3:0] PcIndex = 4'hF;

  // word width of the datapath
  localparam int unsigned DataW = 32;

  // condition flags
  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } nzcv_t;

  // barrel shifter output
  typedef struct packed {
    logic [DataW-1:0] value;
    logic             carry;
  } shift_res_t;

  // alu output
  typedef struct packed {
    logic [DataW-1:0] result;
    logic             write;
    nzcv_t            flags;
  } alu_res_t;

endpackage

`default_nettype wire

// ----- sv/armdp_shifter.sv -----
`default_nettype none

module armdp_shifter (
  input  logic [31:0]             instr_i,
  input  logic [31:0]             rm_i,
  input  logic [31:0]             rs_i,
  input  logic                    c_i,
  output armdp_pkg::shift_res_t   res_o
);

  logic [4:0]  rot_amt;
  logic [63:0] imm_w;
  logic [31:0] imm_rot;
  logic [31:0] val;
  logic [7:0]  rs_amt;
  logic [7:0]  amt;
  logic [4:0]  sh;
  logic [32:0] lsl_w;
  logic [32:0] lsr_w;
  logic [32:0] asr_w;
  logic [63:0] ror_w;
  logic [31:0] fill;
  logic        reg_form;
  armdp_pkg::shift_e sh_type;

  // rotated 8-bit immediate
  assign rot_amt = {instr_i[11:8], 1'b0};
  assign imm_w   = {24'd0, instr_i[7:0], 24'd0, instr_i[7:0]} >> rot_amt;
  assign imm_rot = imm_w[31:0];

  // shift amount and value, pc reads one word further in register form
  assign reg_form = instr_i[4];
  assign sh_type  = armdp_pkg::shift_e'(instr_i[6:5]);
  assign val      = (reg_form && (instr_i[3:0] == armdp_pkg::PcIndex)) ? rm_i + 32'd4 : rm_i;
  assign rs_amt   = rs_i[7:0] + ((instr_i[11:8] == armdp_pkg::PcIndex) ? 8'd4 : 8'd0);
  assign amt      = reg_form ? rs_amt : {3'd0, instr_i[11:7]};
  assign sh       = amt[4:0];

  // shifts with the carry bit carried alongside
  assign lsl_w = {1'b0, val} << sh;
  assign lsr_w = {val, 1'b0} >> sh;
  assign asr_w = 33'($signed({val, 1'b0}) >>> sh);
  assign ror_w = {val, val} >> sh;
  assign fill  = {32{val[31]}};

  // select operand 2 and shifter carry
  always_comb begin
    res_o.value = val;
    res_o.carry = c_i;
    if (instr_i[25]) begin
      res_o.value = imm_rot;
      res_o.carry = (rot_amt == 5'd0) ? c_i : imm_rot[31];
    end else if (amt == 8'd0) begin
      if (!reg_form) begin
        unique case (sh_type)
          armdp_pkg::SH_LSL: begin
            res_o.value = val;
            res_o.carry = c_i;
          end
          armdp_pkg::SH_LSR: begin
            res_o.value = 32'd0;
            res_o.carry = val[31];
          end
          armdp_pkg::SH_ASR: begin
            res_o.value = fill;
            res_o.carry = val[31];
          end
          armdp_pkg::SH_ROR: begin
            res_o.value = {c_i, val[31:1]};
            res_o.carry = val[0];
          end
          default: begin
            res_o.value = val;
            res_o.carry = c_i;
          end
        endcase
      end
    end else if (amt[7:5] != 3'd0) begin
      unique case (sh_type)
        armdp_pkg::SH_LSL: begin
          res_o.value = 32'd0;
          res_o.carry = (amt == 8'd32) && val[0];
        end
        armdp_pkg::SH_LSR: begin
          res_o.value = 32'd0;
          res_o.carry = (amt == 8'd32) && val[31];
        end
        armdp_pkg::SH_ASR: begin
          res_o.value = fill;
          res_o.carry = val[31];
        end
        armdp_pkg::SH_ROR: begin
          res_o.value = ror_w[31:0];
          res_o.carry = ror_w[31];
        end
        default: begin
          res_o.value = val;
          res_o.carry = c_i;
        end
      endcase
    end else begin
      unique case (sh_type)
        armdp_pkg::SH_LSL: begin
          res_o.value = lsl_w[31:0];
          res_o.carry = lsl_w[32];
        end
        armdp_pkg::SH_LSR: begin
          res_o.value = lsr_w[32:1];
          res_o.carry = lsr_w[0];
        end
        armdp_pkg::SH_ASR: begin
          res_o.value = asr_w[32:1];
          res_o.carry = asr_w[0];
        end
        armdp_pkg::SH_ROR: begin
          res_o.value = ror_w[31:0];
          res_o.carry = ror_w[31];
        end
        default: begin
          res_o.value = val;
          res_o.carry = c_i;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/armdp_alu.sv -----
`default_nettype none

module armdp_alu (
  input  logic [31:0]            instr_i,
  input  logic [31:0]            rn_i,
  input  armdp_pkg::shift_res_t  op2_i,
  input  armdp_pkg::nzcv_t       flags_i,
  output armdp_pkg::alu_res_t    res_o
);

  armdp_pkg::op_e op;
  logic           set_flags;
  logic           active;
  logic           is_logic;
  logic [31:0]    p;
  logic [31:0]    q;
  logic           ci;
  logic [31:0]    logic_r;
  logic [32:0]    sum;
  logic [31:0]    r;
  logic           add_v;

  assign op        = armdp_pkg::op_e'(instr_i[24:21]);
  assign set_flags = instr_i[20];
  // opcodes up to rsc always run, test and compare only with s set
  assign active    = !instr_i[24] || (!instr_i[23] && set_flags);

  // operand routing, subtraction as add of the inverse with carry in
  always_comb begin
    p        = rn_i;
    q        = op2_i.value;
    ci       = 1'b0;
    is_logic = 1'b0;
    logic_r  = rn_i & op2_i.value;
    unique case (op)
      armdp_pkg::OP_AND, armdp_pkg::OP_TST: begin
        is_logic = 1'b1;
        logic_r  = rn_i & op2_i.value;
      end
      armdp_pkg::OP_EOR, armdp_pkg::OP_TEQ: begin
        is_logic = 1'b1;
        logic_r  = rn_i ^ op2_i.value;
      end
      armdp_pkg::OP_SUB, armdp_pkg::OP_CMP: begin
        q  = ~op2_i.value;
        ci = 1'b1;
      end
      armdp_pkg::OP_RSB: begin
        p  = op2_i.value;
        q  = ~rn_i;
        ci = 1'b1;
      end
      armdp_pkg::OP_ADD, armdp_pkg::OP_CMN: begin
        ci = 1'b0;
      end
      armdp_pkg::OP_ADC: begin
        ci = flags_i.c;
      end
      armdp_pkg::OP_SBC: begin
        q  = ~op2_i.value;
        ci = flags_i.c;
      end
      armdp_pkg::OP_RSC: begin
        p  = op2_i.value;
        q  = ~rn_i;
        ci = flags_i.c;
      end
      default: begin
        ci = 1'b0;
      end
    endcase
  end

  // 33-bit adder, carry out is not-borrow for subtraction
  assign sum   = {1'b0, p} + {1'b0, q} + {32'd0, ci};
  assign r     = is_logic ? logic_r : sum[31:0];
  assign add_v = (~(p[31] ^ q[31])) & (p[31] ^ sum[31]);

  // result and flag update
  always_comb begin
    res_o.write  = !instr_i[24];
    res_o.result = instr_i[24] ? 32'd0 : r;
    res_o.flags  = flags_i;
    if (active && set_flags) begin
      res_o.flags.n = r[31];
      res_o.flags.z = (r == 32'd0);
      res_o.flags.c = is_logic ? op2_i.carry : sum[32];
      res_o.flags.v = is_logic ? flags_i.v : add_v;
    end
  end

endmodule

`default_nettype wire

// ----- sv/arm_data_processing_alu_unit.sv -----
// channel | direction | handshake              | payload
// --------+-----------+------------------------+------------------------------------------
// in      | request   | in_valid_i, in_ready_o | instruction_i, rn_value_i, rm_value_i,
//         |           |                        | rs_value_i
// out     | result    | out_valid_o, out_ready_i | result_o, dest_reg_o, write_dest_o,
//         |           |                        | flag_n_o, flag_z_o, flag_c_o, flag_v_o
//
// one instruction per cycle while results are taken; a request passes the request register, then the result register
// the request register feeds shifter and alu in one pass into the result register
// the nzcv register is updated as an instruction moves into the result register
// reset clears the valid bits and the flags to zero
// a stalled result holds the request register, which takes a new request once it drains
`default_nettype none

module arm_data_processing_alu_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instruction_i,
  input  logic [31:0] rn_value_i,
  input  logic [31:0] rm_value_i,
  input  logic [31:0] rs_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_o,
  output logic [3:0]  dest_reg_o,
  output logic        write_dest_o,
  output logic        flag_n_o,
  output logic        flag_z_o,
  output logic        flag_c_o,
  output logic        flag_v_o
);

  logic                  req_valid_q;
  logic [31:0]           instr_q;
  logic [31:0]           rn_q;
  logic [31:0]           rm_q;
  logic [31:0]           rs_q;
  logic                  out_valid_q;
  logic [31:0]           result_q;
  logic [3:0]            dest_q;
  logic                  write_q;
  armdp_pkg::nzcv_t      out_flags_q;
  armdp_pkg::nzcv_t      flags_q;
  armdp_pkg::nzcv_t      flags_d;
  armdp_pkg::shift_res_t op2;
  armdp_pkg::alu_res_t   alu_res;
  logic                  advance;
  logic                  take;

  // handshake
  assign advance    = req_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || advance;
  assign take       = in_valid_i && in_ready_o;

  // request register valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      instr_q <= instruction_i;
      rn_q    <= rn_value_i;
      rm_q    <= rm_value_i;
      rs_q    <= rs_value_i;
    end
  end

  // operand 2
  armdp_shifter u_shifter (
    .instr_i (instr_q),
    .rm_i    (rm_q),
    .rs_i    (rs_q),
    .c_i     (flags_q.c),
    .res_o   (op2)
  );

  // alu and flag logic
  armdp_alu u_alu (
    .instr_i (instr_q),
    .rn_i    (rn_q),
    .op2_i   (op2),
    .flags_i (flags_q),
    .res_o   (alu_res)
  );

  assign flags_d = advance ? alu_res.flags : flags_q;

  // flag state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  // result register valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q    <= alu_res.result;
      dest_q      <= instr_q[15:12];
      write_q     <= alu_res.write;
      out_flags_q <= alu_res.flags;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign result_o     = result_q;
  assign dest_reg_o   = dest_q;
  assign write_dest_o = write_q;
  assign flag_n_o     = out_flags_q.n;
  assign flag_z_o     = out_flags_q.z;
  assign flag_c_o     = out_flags_q.c;
  assign flag_v_o     = out_flags_q.v;

`ifndef ASSERT_OFF
  // a result with no register write carries zero
  a_nowrite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !write_q |-> result_q == 32'd0)
    else $error("result not zero without register write");

  // flags move only with an instruction leaving the request register
  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(flags_q))
    else $error("flags changed without an instruction");

  // a shown result carries the current flag state
  a_out_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_flags_q == flags_q)
    else $error("result flags differ from flag state");

  // an instruction that moves on always yields a result
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("instruction lost between stages");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  // one data-processing request as offered to the block
  typedef struct {
    logic [31:0] ins;
    logic [31:0] rn;
    logic [31:0] rm;
    logic [31:0] rs;
    int unsigned gap;
    bit          drain;
  } dp_req_t;

  // what the execute stage should hand back for one request
  typedef struct {
    logic [31:0]      result;
    logic [3:0]       dest;
    logic             wr;
    armdp_pkg::nzcv_t flags;
  } dp_res_t;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        out_ready = 1'b0;
  logic [31:0] instr     = '0;
  logic [31:0] rn_v      = '0;
  logic [31:0] rm_v      = '0;
  logic [31:0] rs_v      = '0;

  logic        in_ready_o;
  logic        out_valid_o;
  logic [31:0] result_o;
  logic [3:0]  dest_reg_o;
  logic        write_dest_o;
  logic        flag_n_o;
  logic        flag_z_o;
  logic        flag_c_o;
  logic        flag_v_o;

  dp_req_t          req_q[$];
  dp_res_t          expected_q[$];
  armdp_pkg::nzcv_t flags_model = '0;

  logic        in_fire    = 1'b0;
  logic        out_fire   = 1'b0;
  int unsigned error_count  = 0;
  int unsigned results_seen = 0;
  int unsigned reqs_built   = 0;
  bit          tx_calm      = 1'b0;
  bit          rx_calm      = 1'b0;
  int unsigned gap_cnt      = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;

  arm_data_processing_alu_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .instruction_i(instr),
    .rn_value_i   (rn_v),
    .rm_value_i   (rm_v),
    .rs_value_i   (rs_v),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .result_o     (result_o),
    .dest_reg_o   (dest_reg_o),
    .write_dest_o (write_dest_o),
    .flag_n_o     (flag_n_o),
    .flag_z_o     (flag_z_o),
    .flag_c_o     (flag_c_o),
    .flag_v_o     (flag_v_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // rotate right, amount taken modulo 32
  function automatic logic [31:0] ror32(logic [31:0] v, int unsigned amt);
    logic [63:0] dbl;
    dbl = {v, v} >> (amt % 32);
    return dbl[31:0];
  endfunction

  // operand 2 and shifter carry
  function automatic armdp_pkg::shift_res_t barrel_shift(logic [31:0] ins, logic [31:0] rm,
                                                         logic [31:0] rs, logic cin);
    armdp_pkg::shift_res_t o;
    armdp_pkg::shift_e     kind;
    logic [31:0]           v;
    logic [31:0]           amt_src;
    int unsigned           amt;
    int unsigned           rot;
    kind = armdp_pkg::shift_e'(ins[6:5]);
    v    = rm;
    // rotated 8-bit immediate
    if (ins[25]) begin
      rot     = 2 * ins[11:8];
      o.value = ror32({24'd0, ins[7:0]}, rot);
      o.carry = (rot != 0) ? o.value[31] : cin;
      return o;
    end
    if (!ins[4]) begin
      amt = 32'(ins[11:7]);
      // a zero amount means lsl #0, a shift by 32 or rrx
      if (amt == 0) begin
        case (kind)
          armdp_pkg::SH_LSL: begin
            o.value = v;
            o.carry = cin;
          end
          armdp_pkg::SH_LSR: begin
            o.value = '0;
            o.carry = v[31];
          end
          armdp_pkg::SH_ASR: begin
            o.value = {32{v[31]}};
            o.carry = v[31];
          end
          default: begin
            o.value = {cin, v[31:1]};
            o.carry = v[0];
          end
        endcase
        return o;
      end
    end else begin
      // register amount, pc reads one word further on
      if (ins[3:0] == armdp_pkg::PcIndex) v = v + 32'd4;
      amt_src = rs;
      if (ins[11:8] == armdp_pkg::PcIndex) amt_src = rs + 32'd4;
      amt = 32'(amt_src[7:0]);
      if (amt == 0) begin
        o.value = v;
        o.carry = cin;
        return o;
      end
      if (amt >= 32) begin
        case (kind)
          armdp_pkg::SH_LSL: begin
            o.value = '0;
            o.carry = (amt == 32) ? v[0] : 1'b0;
            return o;
          end
          armdp_pkg::SH_LSR: begin
            o.value = '0;
            o.carry = (amt == 32) ? v[31] : 1'b0;
            return o;
          end
          armdp_pkg::SH_ASR: begin
            o.value = {32{v[31]}};
            o.carry = v[31];
            return o;
          end
          default: begin
            if (amt % 32 == 0) begin
              o.value = v;
              o.carry = v[31];
              return o;
            end
            amt = amt % 32;
          end
        endcase
      end
    end
    // amount 1..31
    case (kind)
      armdp_pkg::SH_LSL: begin
        o.value = v << amt;
        o.carry = v[32 - amt];
      end
      armdp_pkg::SH_LSR: begin
        o.value = v >> amt;
        o.carry = v[amt - 1];
      end
      armdp_pkg::SH_ASR: begin
        o.value = $signed(v) >>> amt;
        o.carry = v[amt - 1];
      end
      default: begin
        o.value = ror32(v, amt);
        o.carry = v[amt - 1];
      end
    endcase
    return o;
  endfunction

  // one instruction through shifter and alu, with the flags it leaves
  function automatic dp_res_t execute_dp(logic [31:0] ins, logic [31:0] a, logic [31:0] rm,
                                         logic [31:0] rs, armdp_pkg::nzcv_t fl);
    dp_res_t               o;
    armdp_pkg::shift_res_t sh;
    armdp_pkg::op_e        op;
    logic                  s;
    logic                  is_logic;
    logic                  cin;
    logic                  k;
    logic                  c;
    logic                  v;
    logic [31:0]           b;
    logic [31:0]           r;
    logic [31:0]           x;
    logic [31:0]           y;
    logic [32:0]           wide;
    op       = armdp_pkg::op_e'(ins[24:21]);
    s        = ins[20];
    cin      = fl.c;
    c        = fl.c;
    v        = fl.v;
    r        = '0;
    is_logic = 1'b0;
    sh       = barrel_shift(ins, rm, rs, cin);
    b        = sh.value;
    o.flags  = fl;
    o.dest   = ins[15:12];
    o.wr     = (op <= armdp_pkg::OP_RSC);
    // compares only act with s set; orr, mov, bic and mvn do nothing
    if (op <= armdp_pkg::OP_RSC || (op <= armdp_pkg::OP_CMN && s)) begin
      case (op)
        armdp_pkg::OP_AND, armdp_pkg::OP_TST: begin
          r        = a & b;
          is_logic = 1'b1;
        end
        armdp_pkg::OP_EOR, armdp_pkg::OP_TEQ: begin
          r        = a ^ b;
          is_logic = 1'b1;
        end
        armdp_pkg::OP_ADD, armdp_pkg::OP_ADC, armdp_pkg::OP_CMN: begin
          k    = (op == armdp_pkg::OP_ADC) ? cin : 1'b0;
          wide = {1'b0, a} + {1'b0, b} + {32'd0, k};
          r    = wide[31:0];
          c    = wide[32];
          v    = ~(a[31] ^ b[31]) & (a[31] ^ r[31]);
        end
        default: begin
          if (op == armdp_pkg::OP_RSB || op == armdp_pkg::OP_RSC) begin
            x = b;
            y = a;
          end else begin
            x = a;
            y = b;
          end
          k = (op == armdp_pkg::OP_SBC || op == armdp_pkg::OP_RSC) ? ~cin : 1'b0;
          r = x - y - {31'd0, k};
          c = ({1'b0, x} >= ({1'b0, y} + {32'd0, k}));
          v = (x[31] ^ y[31]) & (x[31] ^ r[31]);
        end
      endcase
      if (s) begin
        o.flags.n = r[31];
        o.flags.z = (r == '0);
        o.flags.c = is_logic ? sh.carry : c;
        o.flags.v = v;
      end
    end
    o.result = o.wr ? r : '0;
    return o;
  endfunction

  // instruction word with random condition and ignored bits
  function automatic logic [31:0] dp_word(armdp_pkg::op_e op, bit imm, bit s, logic [3:0] rn,
                                          logic [3:0] rd, logic [11:0] op2);
    logic [31:0] w;
    w        = $urandom;
    w[25]    = imm;
    w[24:21] = op;
    w[20]    = s;
    w[19:16] = rn;
    w[15:12] = rd;
    w[11:0]  = op2;
    return w;
  endfunction

  function automatic logic [11:0] imm_op2(logic [3:0] rot, logic [7:0] imm8);
    return {rot, imm8};
  endfunction

  function automatic logic [11:0] shi_op2(logic [4:0] amt, armdp_pkg::shift_e kind,
                                          logic [3:0] rm);
    return {amt, kind, 1'b0, rm};
  endfunction

  // bit 7 is don't-care here, so it is randomised
  function automatic logic [11:0] shr_op2(logic [3:0] rs, armdp_pkg::shift_e kind,
                                          logic [3:0] rm);
    logic b7;
    b7 = 1'($urandom_range(0, 1));
    return {rs, b7, kind, 1'b1, rm};
  endfunction

  // operand value biased towards the corners
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // shift register value, low byte steered to the interesting amounts
  function automatic logic [31:0] pick_amount();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 4))
      0:       w[7:0] = 8'($urandom_range(0, 33));
      1:       w[7:0] = 8'(32 * $urandom_range(0, 7));
      2:       w[7:0] = 8'($urandom_range(252, 255));
      default: ;
    endcase
    return w;
  endfunction

  // push a request, with the sender's gap drawn from the current mode
  task automatic queue_req(logic [31:0] ins, logic [31:0] rn, logic [31:0] rm,
                           logic [31:0] rs, bit drain);
    dp_req_t q;
    if (reqs_built % 60 == 0) tx_calm = ($urandom_range(0, 2) == 0);
    q.ins   = ins;
    q.rn    = rn;
    q.rm    = rm;
    q.rs    = rs;
    q.gap   = tx_calm ? 0 : $urandom_range(0, 14);
    q.drain = drain;
    req_q.push_back(q);
    reqs_built++;
  endtask

  // request driver
  always @(negedge clk_i) begin
    dp_req_t nxt;
    if (rst_ni && (!in_valid || in_fire)) begin
      if (req_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (req_q[0].drain && expected_q.size() != 0) begin
        in_valid <= 1'b0;
      end else if (gap_cnt < req_q[0].gap) begin
        gap_cnt++;
        in_valid <= 1'b0;
      end else begin
        nxt     = req_q.pop_front();
        gap_cnt = 0;
        instr    <= nxt.ins;
        rn_v     <= nxt.rn;
        rm_v     <= nxt.rm;
        rs_v     <= nxt.rs;
        in_valid <= 1'b1;
      end
    end
  end

  // long receiver hold-off, once, so the block backs up
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= 300) begin
        hold_left <= 400;
        hold_done <= 1'b1;
      end
    end
  end

  // result receiver with random stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) begin
        if (results_seen % 64 == 0) rx_calm = ($urandom_range(0, 2) == 0);
        stall_left = rx_calm ? 0 : $urandom_range(0, 14);
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: check results, then predict newly taken requests
  always @(posedge clk_i) begin
    dp_res_t want;
    dp_res_t pred;
    if (rst_ni) begin
      out_fire <= out_valid_o && out_ready;
      in_fire  <= in_valid && in_ready_o;
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result: result %h rd %0d wr %b nzcv %b%b%b%b",
                     result_o, dest_reg_o, write_dest_o,
                     flag_n_o, flag_z_o, flag_c_o, flag_v_o);
        end else begin
          want = expected_q.pop_front();
          if (result_o !== want.result || dest_reg_o !== want.dest ||
              write_dest_o !== want.wr ||
              {flag_n_o, flag_z_o, flag_c_o, flag_v_o} !== want.flags) begin
            error_count++;
            if (error_count <= 10)
              $display("mismatch at result %0d: exp result %h rd %0d wr %b nzcv %b,",
                       results_seen, want.result, want.dest, want.wr, want.flags,
                       " got result %h rd %0d wr %b nzcv %b%b%b%b",
                       result_o, dest_reg_o, write_dest_o,
                       flag_n_o, flag_z_o, flag_c_o, flag_v_o);
          end
        end
      end
      if (in_valid && in_ready_o) begin
        pred        = execute_dp(instr, rn_v, rm_v, rs_v, flags_model);
        flags_model = pred.flags;
        expected_q.push_back(pred);
      end
    end
  end

  // stimulus and end of run
  initial begin
    armdp_pkg::op_e op;
    bit             imm;
    bit             s;
    logic [11:0]    op2;
    logic [31:0]    ins;

    // directed: operations, flag corners and shifter special cases
    queue_req(dp_word(armdp_pkg::OP_AND, 1'b1, 1'b1, 4'd0, 4'd1, imm_op2(4'd0, 8'hFF)),
              '1, '0, '0, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_EOR, 1'b1, 1'b1, 4'd2, 4'd3, imm_op2(4'd1, 8'hFF)),
              '0, '0, '0, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_ADD, 1'b1, 1'b1, 4'd4, 4'd5, imm_op2(4'd0, 8'h01)),
              32'h7FFF_FFFF, '0, '0, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_ADD, 1'b1, 1'b1, 4'd6, 4'd7, imm_op2(4'd0, 8'h01)),
              '1, '0, '0, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_ADC, 1'b1, 1'b1, 4'd8, 4'd9, imm_op2(4'd0, 8'h00)),
              '0, '0, '0, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_SUB, 1'b1, 1'b1, 4'd1, 4'd2, imm_op2(4'd0, 8'h05)),
              32'd5, '0, '0, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_SUB, 1'b1, 1'b1, 4'd1, 4'd2, imm_op2(4'd0, 8'h01)),
              '0, '0, '0, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_RSB, 1'b0, 1'b1, 4'd3, 4'd4,
                      shi_op2(5'd0, armdp_pkg::SH_LSL, 4'd5)),
              32'd1, 32'h8000_0000, '0, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_SBC, 1'b0, 1'b1, 4'd3, 4'd4,
                      shi_op2(5'd0, armdp_pkg::SH_LSL, 4'd5)),
              32'h8000_0000, 32'd1, '0, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_RSC, 1'b0, 1'b1, 4'd3, 4'd15,
                      shi_op2(5'd0, armdp_pkg::SH_LSL, 4'd5)),
              '1, '0, '0, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_TST, 1'b0, 1'b1, 4'd1, 4'd2,
                      shi_op2(5'd3, armdp_pkg::SH_LSL, 4'd3)),
              '1, '0, '0, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_TEQ, 1'b0, 1'b1, 4'd1, 4'd2,
                      shi_op2(5'd31, armdp_pkg::SH_ROR, 4'd3)),
              32'h1234_5678, '1, '0, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_CMP, 1'b0, 1'b1, 4'd1, 4'd2,
                      shi_op2(5'd1, armdp_pkg::SH_LSR, 4'd3)),
              32'h0000_0001, 32'h0000_0002, '0, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_CMN, 1'b1, 1'b1, 4'd1, 4'd2, imm_op2(4'd0, 8'h01)),
              '1, '0, '0, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_CMP, 1'b1, 1'b0, 4'd1, 4'd2, imm_op2(4'd0, 8'h00)),
              '0, '0, '0, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_ORR, 1'b1, 1'b1, 4'd1, 4'd2, imm_op2(4'd0, 8'hFF)),
              '1, '1, '1, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_MOV, 1'b1, 1'b1, 4'd1, 4'd2, imm_op2(4'd0, 8'h00)),
              '0, '0, '0, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_BIC, 1'b0, 1'b1, 4'd1, 4'd2,
                      shi_op2(5'd4, armdp_pkg::SH_ASR, 4'd3)),
              '1, '1, '1, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_MVN, 1'b0, 1'b1, 4'd1, 4'd2,
                      shr_op2(4'd4, armdp_pkg::SH_ROR, 4'd3)),
              '1, '1, '1, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_AND, 1'b0, 1'b1, 4'd1, 4'd2,
                      shi_op2(5'd0, armdp_pkg::SH_LSR, 4'd3)),
              '1, 32'h8000_0000, '0, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_AND, 1'b0, 1'b1, 4'd1, 4'd2,
                      shi_op2(5'd0, armdp_pkg::SH_ASR, 4'd3)),
              '1, 32'h8000_0001, '0, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_EOR, 1'b0, 1'b1, 4'd1, 4'd2,
                      shi_op2(5'd0, armdp_pkg::SH_ROR, 4'd3)),
              '0, 32'h0000_0003, '0, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_AND, 1'b0, 1'b1, 4'd1, 4'd2,
                      shr_op2(4'd4, armdp_pkg::SH_LSL, 4'd3)),
              '1, 32'h0000_0001, 32'd32, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_AND, 1'b0, 1'b1, 4'd1, 4'd2,
                      shr_op2(4'd4, armdp_pkg::SH_LSR, 4'd3)),
              '1, '1, 32'd40, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_AND, 1'b0, 1'b1, 4'd1, 4'd2,
                      shr_op2(4'd4, armdp_pkg::SH_ASR, 4'd3)),
              '1, 32'h8000_0000, 32'hFF, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_EOR, 1'b0, 1'b1, 4'd1, 4'd2,
                      shr_op2(4'd4, armdp_pkg::SH_ROR, 4'd3)),
              '0, 32'h8000_0001, 32'd64, 1'b0);
    // pc as rs wraps the low byte to zero, pc as rm adds four
    queue_req(dp_word(armdp_pkg::OP_ADD, 1'b0, 1'b1, 4'd1, 4'd2,
                      shr_op2(4'd15, armdp_pkg::SH_LSL, 4'd15)),
              32'd0, 32'hFFFF_FFFC, 32'h0000_00FC, 1'b0);
    queue_req(dp_word(armdp_pkg::OP_SUB, 1'b0, 1'b1, 4'd15, 4'd15,
                      shr_op2(4'd4, armdp_pkg::SH_ROR, 4'd3)),
              32'h0000_0008, 32'h0000_00F0, 32'h0000_0100, 1'b0);

    // random part: mostly well-formed instructions, some raw words
    for (int i = 0; i < 825; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        op = armdp_pkg::op_e'($urandom_range(0, 15));
        s  = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 2))
          0: begin
            imm = 1'b1;
            op2 = imm_op2(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
          end
          1: begin
            imm = 1'b0;
            op2 = shi_op2(5'($urandom_range(0, 31)),
                          armdp_pkg::shift_e'($urandom_range(0, 3)),
                          4'($urandom_range(0, 15)));
          end
          default: begin
            imm = 1'b0;
            op2 = shr_op2(4'($urandom_range(0, 15)),
                          armdp_pkg::shift_e'($urandom_range(0, 3)),
                          4'($urandom_range(0, 15)));
          end
        endcase
        ins = dp_word(op, imm, s, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      op2);
      end else begin
        ins = $urandom;
      end
      queue_req(ins, pick_word(), pick_word(), pick_amount(), i == 600);
    end

    // reset
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // wait for all requests taken and all results back
    while (req_q.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
